// File: rtl/core/mfq_pkg.sv
// Shared types, constants and helper functions for the feedback queue scheduler.
package mfq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int QW          = $clog2(QUEUE_DEPTH);
    localparam int CW          = $clog2(QUEUE_DEPTH + 1);
    localparam int SW          = CW + 1;
    localparam int AW          = $clog2(3 * QUEUE_DEPTH);
    localparam int ID_W        = 16;
    localparam int TIME_W      = 16;
    localparam int ENTRY_W     = ID_W + TIME_W;
    localparam logic [TIME_W-1:0] RESET_SLICE = TIME_W'(1000);

    typedef enum logic [2:0] {
        ACT_MOVED    = 3'd0,
        ACT_FINISHED = 3'd1,
        ACT_QUEUED   = 3'd2,
        ACT_BLOCKED  = 3'd3,
        ACT_DROPPED  = 3'd4,
        ACT_IDLE     = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_SERVE
    } t_state;

    // Write request into the queue store
    typedef struct packed {
        logic               en;
        logic [AW-1:0]      addr;
        logic [ENTRY_W-1:0] data;
    } t_wr_req;

    // Result of the shared subtract and compare unit
    typedef struct packed {
        logic              gt;
        logic [TIME_W-1:0] diff;
    } t_alu_res;

    // Map a queue index (0..2) and a slot to a flat store address
    function automatic logic [AW-1:0] f_addr(input logic [1:0] idx, input logic [QW-1:0] slot);
        logic [AW-1:0] base;
        unique case (idx)
            2'd1:    base = AW'(QUEUE_DEPTH);
            2'd2:    base = AW'(2 * QUEUE_DEPTH);
            default: base = '0;
        endcase
        return base + AW'(slot);
    endfunction

    // Tail slot: head plus count, wrapped once
    function automatic logic [QW-1:0] f_tail(input logic [QW-1:0] head, input logic [CW-1:0] cnt);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(cnt);
        if (sum >= SW'(QUEUE_DEPTH)) begin
            sum = sum - SW'(QUEUE_DEPTH);
        end
        return sum[QW-1:0];
    endfunction

    // Advance a head pointer with wrap
    function automatic logic [QW-1:0] f_next_head(input logic [QW-1:0] head);
        logic [QW-1:0] nxt;
        if (head == QW'(QUEUE_DEPTH - 1)) begin
            nxt = '0;
        end else begin
            nxt = head + QW'(1);
        end
        return nxt;
    endfunction

endpackage

// File: rtl/core/mfq_store.sv
// Entry store for the three queue levels: one write port, one registered read port.
module mfq_store (
    input  logic                        i_clk,
    input  mfq_pkg::t_wr_req            i_wr,
    input  logic                        i_rd_en,
    input  logic [mfq_pkg::AW-1:0]      i_rd_addr,
    output logic [mfq_pkg::ENTRY_W-1:0] o_rd_data
);

    logic [mfq_pkg::ENTRY_W-1:0] r_mem [0:3*mfq_pkg::QUEUE_DEPTH-1];
    logic [mfq_pkg::ENTRY_W-1:0] r_rd_data;

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Read one entry, registered
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/mfq_alu.sv
// Shared subtract and compare unit: remaining time against the time slice.
module mfq_alu (
    input  logic [mfq_pkg::TIME_W-1:0] i_time,
    input  logic [mfq_pkg::TIME_W-1:0] i_slice,
    output mfq_pkg::t_alu_res          o_res
);

    logic [mfq_pkg::TIME_W:0] w_sub;

    // Subtract with borrow; greater-than means no borrow and a nonzero difference
    assign w_sub      = {1'b0, i_time} - {1'b0, i_slice};
    assign o_res.diff = w_sub[mfq_pkg::TIME_W-1:0];
    assign o_res.gt   = !w_sub[mfq_pkg::TIME_W] && (w_sub[mfq_pkg::TIME_W-1:0] != '0);

endmodule

// File: rtl/core/multilevel_feedback_queue_scheduler_core.sv
// Top level of the three-level feedback queue scheduler: sequencer, pointers and results.
//
//  channel  | signals                                             | handshake
//  ---------+-----------------------------------------------------+-------------------------
//  command  | i_cmd i_proc_id i_start_level i_service_time        | start high, busy low
//           | i_memory_granted                                    |
//  result   | o_out_id o_served_level o_action o_time_left o_last | o_result_valid, 1 cycle
//  config   | i_cfg_data                                          | i_cfg_valid & o_cfg_ready
//
// An enqueue transaction is handled in its accept cycle; its result shows the next cycle.
// A schedule transaction serves up to three levels in turn (idle if all queues are empty):
// each service reads the queue store through its single registered read port, then runs the
// shared subtract unit and writes back. Each result shows in the cycle after its service.
// Reset (synchronous, active low) empties all queues and loads the slice with 1000;
// the store itself is not cleared. The receiver cannot stall results.
module multilevel_feedback_queue_scheduler_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_cmd,
    input  logic [mfq_pkg::ID_W-1:0]         i_proc_id,
    input  logic [1:0]                       i_start_level,
    input  logic [mfq_pkg::TIME_W-1:0]       i_service_time,
    input  logic                             i_memory_granted,
    output logic                             o_result_valid,
    output logic [mfq_pkg::ID_W-1:0]         o_out_id,
    output logic [1:0]                       o_served_level,
    output logic [2:0]                       o_action,
    output logic [mfq_pkg::TIME_W-1:0]       o_time_left,
    output logic                             o_last,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mfq_pkg::TIME_W-1:0]       i_cfg_data
);

    mfq_pkg::t_state                   r_state, n_state;
    logic [1:0]                        r_lvl, n_lvl;
    logic [mfq_pkg::QW-1:0]            r_head [0:2];
    logic [mfq_pkg::QW-1:0]            n_head [0:2];
    logic [mfq_pkg::CW-1:0]            r_cnt [0:2];
    logic [mfq_pkg::CW-1:0]            n_cnt [0:2];
    logic [mfq_pkg::TIME_W-1:0]        r_slice;
    logic                              r_res_valid, n_res_valid;
    logic [mfq_pkg::ID_W-1:0]          r_out_id, n_out_id;
    logic [1:0]                        r_out_lvl, n_out_lvl;
    mfq_pkg::t_action                  r_out_act, n_out_act;
    logic [mfq_pkg::TIME_W-1:0]        r_out_tl, n_out_tl;
    logic                              r_out_last, n_out_last;

    mfq_pkg::t_wr_req                  w_wr;
    logic                              w_rd_en;
    logic [mfq_pkg::AW-1:0]            w_rd_addr;
    logic [mfq_pkg::ENTRY_W-1:0]       w_rd_data;
    mfq_pkg::t_alu_res                 w_alu;
    logic [1:0]                        w_sv_idx;
    logic [1:0]                        w_dst_lvl;
    logic [1:0]                        w_dst_idx;
    logic [1:0]                        w_eq_idx;
    logic                              w_more;

    localparam logic [mfq_pkg::CW-1:0] FULL = mfq_pkg::CW'(mfq_pkg::QUEUE_DEPTH);

    mfq_store u_store (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    mfq_alu u_alu (
        .i_time  (w_rd_data[mfq_pkg::TIME_W-1:0]),
        .i_slice (r_slice),
        .o_res   (w_alu)
    );

    assign busy        = (r_state != mfq_pkg::ST_IDLE);
    assign o_cfg_ready = (r_state == mfq_pkg::ST_IDLE);

    // Level indexes for the entry in service, its destination and an enqueue
    assign w_sv_idx  = r_lvl - 2'd1;
    assign w_dst_lvl = (r_lvl == 2'd1) ? 2'd1 : r_lvl - 2'd1;
    assign w_dst_idx = w_dst_lvl - 2'd1;
    assign w_eq_idx  = i_start_level - 2'd1;

    // Sequencer: next state, pointer updates and result fields
    always_comb begin
        n_state     = r_state;
        n_lvl       = r_lvl;
        n_head      = r_head;
        n_cnt       = r_cnt;
        n_res_valid = 1'b0;
        n_out_id    = r_out_id;
        n_out_lvl   = r_out_lvl;
        n_out_act   = r_out_act;
        n_out_tl    = r_out_tl;
        n_out_last  = r_out_last;
        w_wr        = '0;
        w_rd_en     = 1'b0;
        w_rd_addr   = '0;
        w_more      = 1'b0;

        unique case (r_state)
            mfq_pkg::ST_IDLE: begin
                if (start) begin
                    if (!i_cmd) begin
                        // Enqueue: one result, handled right away
                        n_res_valid = 1'b1;
                        n_out_last  = 1'b1;
                        n_out_id    = i_proc_id;
                        n_out_tl    = i_service_time;
                        if (!i_memory_granted) begin
                            n_out_lvl = 2'd0;
                            n_out_act = mfq_pkg::ACT_BLOCKED;
                        end else if (i_start_level == 2'd0) begin
                            n_out_lvl = 2'd0;
                            n_out_act = mfq_pkg::ACT_DROPPED;
                        end else if (r_cnt[w_eq_idx] == FULL) begin
                            n_out_lvl = i_start_level;
                            n_out_act = mfq_pkg::ACT_DROPPED;
                        end else begin
                            n_out_lvl       = i_start_level;
                            n_out_act       = mfq_pkg::ACT_QUEUED;
                            w_wr.en         = 1'b1;
                            w_wr.addr       = mfq_pkg::f_addr(w_eq_idx,
                                mfq_pkg::f_tail(r_head[w_eq_idx], r_cnt[w_eq_idx]));
                            w_wr.data       = {i_proc_id, i_service_time};
                            n_cnt[w_eq_idx] = r_cnt[w_eq_idx] + mfq_pkg::CW'(1);
                        end
                    end else if (r_cnt[2] != '0) begin
                        n_lvl   = 2'd3;
                        n_state = mfq_pkg::ST_POP;
                    end else if (r_cnt[1] != '0) begin
                        n_lvl   = 2'd2;
                        n_state = mfq_pkg::ST_POP;
                    end else if (r_cnt[0] != '0) begin
                        n_lvl   = 2'd1;
                        n_state = mfq_pkg::ST_POP;
                    end else begin
                        // Nothing queued: report idle
                        n_res_valid = 1'b1;
                        n_out_last  = 1'b1;
                        n_out_id    = '0;
                        n_out_lvl   = 2'd0;
                        n_out_act   = mfq_pkg::ACT_IDLE;
                        n_out_tl    = '0;
                    end
                end
            end

            mfq_pkg::ST_POP: begin
                // Read the front entry and drop it from its queue
                w_rd_en          = 1'b1;
                w_rd_addr        = mfq_pkg::f_addr(w_sv_idx, r_head[w_sv_idx]);
                n_head[w_sv_idx] = mfq_pkg::f_next_head(r_head[w_sv_idx]);
                n_cnt[w_sv_idx]  = r_cnt[w_sv_idx] - mfq_pkg::CW'(1);
                n_state          = mfq_pkg::ST_SERVE;
            end

            mfq_pkg::ST_SERVE: begin
                n_res_valid = 1'b1;
                n_out_id    = w_rd_data[mfq_pkg::ENTRY_W-1:mfq_pkg::TIME_W];
                n_out_lvl   = r_lvl;
                if (w_alu.gt) begin
                    // Charge one slice and move down, or rotate at the lowest level; drop if the target is full
                    n_out_tl = w_alu.diff;
                    if (r_cnt[w_dst_idx] == FULL) begin
                        n_out_act = mfq_pkg::ACT_DROPPED;
                    end else begin
                        n_out_act        = mfq_pkg::ACT_MOVED;
                        w_wr.en          = 1'b1;
                        w_wr.addr        = mfq_pkg::f_addr(w_dst_idx,
                            mfq_pkg::f_tail(r_head[w_dst_idx], r_cnt[w_dst_idx]));
                        w_wr.data        = {n_out_id, w_alu.diff};
                        n_cnt[w_dst_idx] = r_cnt[w_dst_idx] + mfq_pkg::CW'(1);
                    end
                end else begin
                    n_out_act = mfq_pkg::ACT_FINISHED;
                    n_out_tl  = '0;
                end

                // Decide whether a lower level is served in this step
                case (r_lvl)
                    2'd3: begin
                        w_more = (n_cnt[2] == '0) && ((n_cnt[1] != '0) || (n_cnt[0] != '0));
                        n_lvl  = (n_cnt[1] != '0) ? 2'd2 : 2'd1;
                    end
                    2'd2: begin
                        w_more = (n_cnt[2] == '0) && (n_cnt[1] == '0) && (n_cnt[0] != '0);
                        n_lvl  = 2'd1;
                    end
                    default: begin
                        w_more = 1'b0;
                    end
                endcase

                n_out_last = !w_more;
                n_state    = w_more ? mfq_pkg::ST_POP : mfq_pkg::ST_IDLE;
            end

            default: begin
                n_state = mfq_pkg::ST_IDLE;
            end
        endcase
    end

    // State, pointers, counts and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mfq_pkg::ST_IDLE;
            r_lvl       <= 2'd0;
            r_head      <= '{default: '0};
            r_cnt       <= '{default: '0};
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lvl       <= n_lvl;
            r_head      <= n_head;
            r_cnt       <= n_cnt;
            r_res_valid <= n_res_valid;
        end
    end

    // Slice register, written through the config channel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice <= mfq_pkg::RESET_SLICE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_slice <= i_cfg_data;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_out_id   <= n_out_id;
        r_out_lvl  <= n_out_lvl;
        r_out_act  <= n_out_act;
        r_out_tl   <= n_out_tl;
        r_out_last <= n_out_last;
    end

    assign o_result_valid = r_res_valid;
    assign o_out_id       = r_out_id;
    assign o_served_level = r_out_lvl;
    assign o_action       = r_out_act;
    assign o_time_left    = r_out_tl;
    assign o_last         = r_out_last;

    // Counts never pass the queue depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt[0] <= FULL) && (r_cnt[1] <= FULL) && (r_cnt[2] <= FULL))
        else $error("queue count beyond depth");

    // Every service produces a result in the next cycle
    a_serve_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mfq_pkg::ST_SERVE) |=> o_result_valid)
        else $error("service without result");

    // An accepted transaction yields a result or keeps the sequencer busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_result_valid || busy))
        else $error("accepted transaction made no progress");

    // The final result coincides with the sequencer being free
    a_last_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_last == !busy))
        else $error("last flag out of step with busy");

endmodule

// File: bench/tb_multilevel_feedback_queue_scheduler_core.sv
// Self-checking bench for the three-level feedback queue scheduler core.
module tb_multilevel_feedback_queue_scheduler_core;
    import mfq_pkg::*;

    localparam int RESET_CYCLES  = 11;
    localparam int DRAIN_CYCLES  = 10;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 30;
    localparam int NUM_PHASES    = 5;
    localparam int QUIET_ITEMS   = 20;
    localparam bit CMD_ENQUEUE   = 1'b0;
    localparam bit CMD_SCHEDULE  = 1'b1;

    // One scheduler result as seen on the result ports
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [1:0]        level;
        t_action           action;
        logic [TIME_W-1:0] time_left;
        logic              last;
    } t_sched_result;

    // Mirror of the three queues; predicts the results of each command transaction
    class queue_mirror;
        logic [ENTRY_W-1:0] store [3][QUEUE_DEPTH];
        int unsigned        head [3];
        int unsigned        count [3];
        logic [TIME_W-1:0]  slice;
        t_sched_result      pending_outcomes [$];
        int unsigned        mismatches;
        int unsigned        results_seen;
        int unsigned        enq_seen;
        int unsigned        step_seen;
        int unsigned        action_hits [6];

        function new();
            slice        = RESET_SLICE;
            mismatches   = 0;
            results_seen = 0;
            enq_seen     = 0;
            step_seen    = 0;
            for (int k = 0; k < 3; k++) begin
                head[k]  = 0;
                count[k] = 0;
            end
            for (int a = 0; a < 6; a++) begin
                action_hits[a] = 0;
            end
        endfunction

        function t_sched_result make(logic [ID_W-1:0] pid, logic [1:0] lvl, t_action act,
                                     logic [TIME_W-1:0] tl);
            t_sched_result r;
            r.id        = pid;
            r.level     = lvl;
            r.action    = act;
            r.time_left = tl;
            r.last      = 1'b0;
            return r;
        endfunction

        // Append at the tail of queue k; refuse when full
        function bit push_entry(int unsigned k, logic [ENTRY_W-1:0] e);
            if (count[k] >= QUEUE_DEPTH) begin
                return 1'b0;
            end
            store[k][(head[k] + count[k]) % QUEUE_DEPTH] = e;
            count[k]++;
            return 1'b1;
        endfunction

        function logic [ENTRY_W-1:0] pop_entry(int unsigned k);
            logic [ENTRY_W-1:0] e;
            e       = store[k][head[k]];
            head[k] = (head[k] + 1) % QUEUE_DEPTH;
            count[k]--;
            return e;
        endfunction

        // Serve the front of level lvl: finish, demote, rotate at the bottom level, or drop if full
        function void serve(int unsigned lvl, output t_sched_result r);
            logic [ENTRY_W-1:0] e;
            logic [ID_W-1:0]    pid;
            logic [TIME_W-1:0]  tl;
            int unsigned        dest;
            e   = pop_entry(lvl - 1);
            pid = e[ENTRY_W-1:TIME_W];
            tl  = e[TIME_W-1:0];
            if (tl > slice) begin
                dest = (lvl > 1) ? lvl - 1 : 1;
                tl   = tl - slice;
                if (push_entry(dest - 1, {pid, tl})) begin
                    r = make(pid, 2'(lvl), ACT_MOVED, tl);
                end else begin
                    r = make(pid, 2'(lvl), ACT_DROPPED, tl);
                end
            end else begin
                r = make(pid, 2'(lvl), ACT_FINISHED, '0);
            end
        endfunction

        // Work out the results of one accepted command transaction
        function void note_command(bit cmd, logic [ID_W-1:0] pid, logic [1:0] lvl,
                                   logic [TIME_W-1:0] st, bit granted);
            t_sched_result res [3];
            int unsigned   n;
            n = 0;
            if (cmd == CMD_ENQUEUE) begin
                enq_seen++;
                if (!granted) begin
                    res[0] = make(pid, 2'd0, ACT_BLOCKED, st);
                end else if (lvl == 2'd0) begin
                    res[0] = make(pid, 2'd0, ACT_DROPPED, st);
                end else if (push_entry(lvl - 1, {pid, st})) begin
                    res[0] = make(pid, lvl, ACT_QUEUED, st);
                end else begin
                    res[0] = make(pid, lvl, ACT_DROPPED, st);
                end
                n = 1;
            end else begin
                step_seen++;
                if (count[2] != 0) begin
                    serve(3, res[n]);
                    n++;
                end
                if (count[1] != 0 && count[2] == 0) begin
                    serve(2, res[n]);
                    n++;
                end
                if (count[0] != 0 && count[1] == 0 && count[2] == 0) begin
                    serve(1, res[n]);
                    n++;
                end
                if (n == 0) begin
                    res[0] = make('0, 2'd0, ACT_IDLE, '0);
                    n = 1;
                end
            end
            res[n-1].last = 1'b1;
            for (int i = 0; i < n; i++) begin
                pending_outcomes.insert(pending_outcomes.size(), res[i]);
            end
        endfunction

        // Compare one result with the oldest prediction
        function void check_result(t_sched_result got);
            t_sched_result want;
            results_seen++;
            if (got.action <= ACT_IDLE) begin
                action_hits[got.action]++;
            end
            if (pending_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("MISMATCH: unexpected result id=%h lvl=%0d act=%0d tl=%h last=%b",
                             got.id, got.level, got.action, got.time_left, got.last);
                end
                return;
            end
            want = pending_outcomes[0];
            pending_outcomes.delete(0);
            if (got.id !== want.id || got.level !== want.level || got.action !== want.action ||
                got.time_left !== want.time_left || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("MISMATCH: expected id=%h lvl=%0d act=%0d tl=%h last=%b",
                             want.id, want.level, want.action, want.time_left, want.last);
                    $display("          actual   id=%h lvl=%0d act=%0d tl=%h last=%b",
                             got.id, got.level, got.action, got.time_left, got.last);
                end
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n          = 1'b0;
    logic                start            = 1'b0;
    logic                busy;
    logic                i_cmd            = 1'b0;
    logic [ID_W-1:0]     i_proc_id        = '0;
    logic [1:0]          i_start_level    = '0;
    logic [TIME_W-1:0]   i_service_time   = '0;
    logic                i_memory_granted = 1'b0;
    logic                o_result_valid;
    logic [ID_W-1:0]     o_out_id;
    logic [1:0]          o_served_level;
    logic [2:0]          o_action;
    logic [TIME_W-1:0]   o_time_left;
    logic                o_last;
    logic                i_cfg_valid      = 1'b0;
    logic                o_cfg_ready;
    logic [TIME_W-1:0]   i_cfg_data       = '0;

    queue_mirror mirror;
    bit          quiet_tail    = 1'b0;
    int unsigned slices_used   = 0;
    int unsigned stall_cycles  = 0;

    multilevel_feedback_queue_scheduler_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cmd            (i_cmd),
        .i_proc_id        (i_proc_id),
        .i_start_level    (i_start_level),
        .i_service_time   (i_service_time),
        .i_memory_granted (i_memory_granted),
        .o_result_valid   (o_result_valid),
        .o_out_id         (o_out_id),
        .o_served_level   (o_served_level),
        .o_action         (o_action),
        .o_time_left      (o_time_left),
        .o_last           (o_last),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    // Generate the clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Check each result strobe against the prediction
    always @(posedge i_clk) begin
        t_sched_result got;
        if (i_rst_n === 1'b1 && o_result_valid === 1'b1) begin
            got.id        = o_out_id;
            got.level     = o_served_level;
            got.action    = t_action'(o_action);
            got.time_left = o_time_left;
            got.last      = o_last;
            mirror.check_result(got);
        end
    end

    // Abort when no transaction of any kind moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if ((start === 1'b1 && busy === 1'b0) || o_result_valid === 1'b1 ||
                (i_cfg_valid === 1'b1 && o_cfg_ready === 1'b1)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // Present one command and hold it until the block takes it
    task automatic send_command(bit cmd, logic [ID_W-1:0] pid, logic [1:0] lvl,
                                logic [TIME_W-1:0] st, bit granted);
        start            <= 1'b1;
        i_cmd            <= cmd;
        i_proc_id        <= pid;
        i_start_level    <= lvl;
        i_service_time   <= st;
        i_memory_granted <= granted;
        do @(posedge i_clk); while (busy !== 1'b0);
        mirror.note_command(cmd, pid, lvl, st, granted);
    endtask

    // Drop start for a random burst now and then
    task automatic pause_maybe();
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    // Hold off until every predicted result has been seen
    task automatic settle();
        start <= 1'b0;
        while (mirror.pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_slice(logic [TIME_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        mirror.slice = value;
        slices_used++;
    endtask

    // Random command; service times cluster around the slice so all outcomes occur
    task automatic random_command(int unsigned enq_pct, logic [1:0] fav_lvl);
        bit                cmd;
        bit                granted;
        logic [1:0]        lvl;
        logic [TIME_W-1:0] st;
        int unsigned       pick;
        int unsigned       near;
        cmd     = ($urandom_range(0, 99) >= enq_pct) ? CMD_SCHEDULE : CMD_ENQUEUE;
        granted = ($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 19) == 0) begin
            lvl = 2'd0;
        end else if ($urandom_range(0, 1) == 1) begin
            lvl = fav_lvl;
        end else begin
            lvl = 2'($urandom_range(1, 3));
        end
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
            st = TIME_W'($urandom);
        end else if (pick == 3) begin
            case ($urandom_range(0, 4))
                0:       st = '0;
                1:       st = TIME_W'(1);
                2:       st = '1;
                3:       st = mirror.slice;
                default: st = mirror.slice + TIME_W'(1);
            endcase
        end else begin
            near = int'(mirror.slice) * $urandom_range(0, 3) + $urandom_range(0, 2);
            st   = (near > 65535) ? '1 : TIME_W'(near);
        end
        send_command(cmd, ID_W'($urandom), lvl, st, granted);
    endtask

    initial begin : stimulus
        logic [TIME_W-1:0] phase_slice [NUM_PHASES];
        int unsigned       phase_enq   [NUM_PHASES];
        logic [1:0]        phase_fav   [NUM_PHASES];
        mirror = new();
        phase_slice = '{TIME_W'(1), TIME_W'(0), TIME_W'(65535),
                        TIME_W'($urandom_range(2, 600)), TIME_W'(300)};
        phase_enq   = '{85, 85, 30, 80, 40};
        phase_fav   = '{2'd2, 2'd2, 2'd3, 2'd1, 2'd3};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty step, field extremes, blocked, level zero, slice boundaries
        send_command(CMD_SCHEDULE, 16'h0000, 2'd0, 16'h0000, 1'b0);
        pause_maybe();
        send_command(CMD_ENQUEUE, 16'hFFFF, 2'd3, 16'hFFFF, 1'b1);
        send_command(CMD_ENQUEUE, 16'h0000, 2'd2, 16'h0000, 1'b1);
        send_command(CMD_ENQUEUE, 16'h1234, 2'd1, 16'd1000, 1'b1);
        pause_maybe();
        send_command(CMD_ENQUEUE, 16'h0005, 2'd3, 16'd1001, 1'b1);
        send_command(CMD_ENQUEUE, 16'hAAAA, 2'd3, 16'h5555, 1'b0);
        send_command(CMD_ENQUEUE, 16'h5555, 2'd0, 16'hAAAA, 1'b1);
        send_command(CMD_ENQUEUE, 16'h0F0F, 2'd0, 16'hF0F0, 1'b0);
        send_command(CMD_ENQUEUE, 16'h00FF, 2'd1, 16'h0001, 1'b1);
        for (int i = 0; i < 12; i++) begin
            pause_maybe();
            send_command(CMD_SCHEDULE, ID_W'($urandom), 2'($urandom), TIME_W'($urandom),
                         1'($urandom));
        end
        settle();

        // Random phases, each under its own slice
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_slice(phase_slice[p]);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == NUM_PHASES - 1 && i >= PHASE_ITEMS - QUIET_ITEMS) begin
                    quiet_tail = 1'b1;
                end
                random_command(phase_enq[p], phase_fav[p]);
                if (i != PHASE_ITEMS - 1) begin
                    pause_maybe();
                end
            end
            settle();
        end

        $display("Covered %0d commands (%0d enqueues, %0d schedule steps) over %0d slices",
                 mirror.enq_seen + mirror.step_seen, mirror.enq_seen, mirror.step_seen,
                 slices_used + 1);
        $display("Checked %0d results: moved %0d finished %0d queued %0d",
                 mirror.results_seen, mirror.action_hits[ACT_MOVED],
                 mirror.action_hits[ACT_FINISHED], mirror.action_hits[ACT_QUEUED]);
        $display("  blocked %0d dropped %0d idle %0d",
                 mirror.action_hits[ACT_BLOCKED], mirror.action_hits[ACT_DROPPED],
                 mirror.action_hits[ACT_IDLE]);
        if (mirror.mismatches == 0 && mirror.pending_outcomes.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches, %0d results still expected", mirror.mismatches,
                     mirror.pending_outcomes.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/mfq_pkg.sv
rtl/core/mfq_store.sv
rtl/core/mfq_alu.sv
rtl/core/multilevel_feedback_queue_scheduler_core.sv
bench/tb_multilevel_feedback_queue_scheduler_core.sv
